>>> hw/rtl/vtd_pkg.sv
// Package: shared constants and the fixed-point multiply function for the Viterbi tag decoder.
`default_nettype none
package vtd_pkg;
    localparam int NUM_TAGS_DEF  = 64;
    localparam int MAX_HYPS_DEF  = 16;
    localparam int MAX_WORDS_DEF = 32;
    localparam int TINY_LSB_DEF  = 1;

    localparam int OP_W       = 2;
    localparam int TAG_W      = 6;
    localparam int SCORE_W    = 32;
    localparam int WIDX_W     = 5;

    localparam logic [OP_W-1:0] OP_LOAD_TRANS = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_INIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_HYP        = 2'd2;

    // Fixed-point fraction product, truncated.
    function automatic logic [SCORE_W-1:0] fx_mul(input logic [SCORE_W-1:0] a,
                                                  input logic [SCORE_W-1:0] b);
        logic [2*SCORE_W-1:0] p;
        p = {{SCORE_W{1'b0}}, a} * {{SCORE_W{1'b0}}, b};
        return p[2*SCORE_W-1:SCORE_W];
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/vtd_mul.sv
// Shared registered fixed-point multiplier with add-tiny saturation option.
`default_nettype none
module vtd_mul
    import vtd_pkg::*;
#(
    parameter int TINY_LSB = TINY_LSB_DEF
)
(
    input  wire logic               clk,
    input  wire logic [SCORE_W-1:0] a,
    input  wire logic [SCORE_W-1:0] b,
    input  wire logic               add_tiny,
    output logic      [SCORE_W-1:0] q
);
    logic [SCORE_W-1:0] prod;
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] q_next;

    always_comb
    begin
        prod = fx_mul(a, b);
        sum = {1'b0, prod} + (SCORE_W+1)'(TINY_LSB);
        if (!add_tiny)
            q_next = prod;
        else if (sum[SCORE_W])
            q_next = {SCORE_W{1'b1}};
        else
            q_next = sum[SCORE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end
endmodule
`default_nettype wire

>>> hw/rtl/viterbi_tag_decoder_core.sv
// Top level: HMM Viterbi tag decoder with one shared multiplier.
//
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | opcode cand_tag source_tag score_value
//         |     |                     | word_end segment_end
// out     | out | out_valid/out_ready | word_index chosen_tag overflow_flag last_out
//
// Load items are written while idle. A first-word hypothesis reads the init table and
// multiplies once; a later one reads the tag and transition tables and multiplies for
// each predecessor, paced by the shared multiplier and the table memory read ports.
// A dropped (overflowing) hypothesis goes straight to the finish state. Traceback scans
// the last word's hypotheses, then emits one result per word and holds on out_ready.
// Reset clears control state and the score registers; tables are undefined until loaded.
`default_nettype none
module viterbi_tag_decoder_core
    import vtd_pkg::*;
#(
    parameter int NUM_TAGS  = NUM_TAGS_DEF,
    parameter int MAX_HYPS  = MAX_HYPS_DEF,
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int TINY_LSB  = TINY_LSB_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    opcode,
    input  wire logic [TAG_W-1:0]   cand_tag,
    input  wire logic [TAG_W-1:0]   source_tag,
    input  wire logic [SCORE_W-1:0] score_value,
    input  wire logic               word_end,
    input  wire logic               segment_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [WIDX_W-1:0]       word_index,
    output logic [TAG_W-1:0]        chosen_tag,
    output logic                    overflow_flag,
    output logic                    last_out
);
    // tables are addressed by the full tag width; NUM_TAGS only gates access
    localparam int TB  = TAG_W;
    localparam int HB  = (MAX_HYPS > 1) ? $clog2(MAX_HYPS) : 1;
    localparam int WB  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int HC  = $clog2(MAX_HYPS + 1);
    localparam int WC  = $clog2(MAX_WORDS + 1);
    localparam int SL  = WB + HB;

    localparam logic [3:0] S_IDLE = 4'd0, S_FW0 = 4'd1, S_FW1 = 4'd2,
                           S_PRD = 4'd3, S_PM1 = 4'd4, S_PM2 = 4'd5, S_PM3 = 4'd6,
                           S_PCMP = 4'd7, S_FIN = 4'd8, S_TB0 = 4'd9, S_TBS = 4'd10,
                           S_TRD = 4'd11, S_TOUT = 4'd12, S_PFW = 4'd13;

    // memories
    logic [SCORE_W-1:0] trans_mem [2**(2*TB)];
    logic [SCORE_W-1:0] init_mem  [2**TB];
    logic [TAG_W-1:0]   tag_mem   [2**SL];
    logic [HB-1:0]      bp_mem    [2**SL];
    logic [SCORE_W-1:0] prev_sc_reg [MAX_HYPS];
    logic [SCORE_W-1:0] cur_sc_reg  [MAX_HYPS];

    logic [3:0]         state_reg;
    logic [WC-1:0]      wc_reg;
    logic [HC-1:0]      hc_reg, phc_reg;
    logic               ovf_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SCORE_W-1:0] em_reg;
    logic               wend_reg, send_reg;
    logic [HC-1:0]      p_reg;
    logic [SCORE_W-1:0] best_reg;
    logic [HB-1:0]      bestp_reg;
    logic               have_reg;
    logic [TAG_W-1:0]   tag_rd_reg;
    logic [SCORE_W-1:0] trans_rd_reg, init_rd_reg;
    logic [HB-1:0]      bp_rd_reg;
    logic [WC-1:0]      tw_reg;
    logic [HB-1:0]      th_reg;
    logic [HC-1:0]      k_reg;

    logic [SCORE_W-1:0] mul_a, mul_b, mul_q;
    logic               mul_tiny;

    vtd_mul #(.TINY_LSB(TINY_LSB)) u_mul (
        .clk(clk), .a(mul_a), .b(mul_b), .add_tiny(mul_tiny), .q(mul_q)
    );

    logic in_fire;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    logic tag_ok_c, src_ok_c;
    assign tag_ok_c = (32'(cand_tag) < 32'(NUM_TAGS));
    assign src_ok_c = (32'(source_tag) < 32'(NUM_TAGS));
    logic tag_ok;
    assign tag_ok = (32'(tag_reg) < 32'(NUM_TAGS));

    logic [SL-1:0] cur_slot, prev_slot, tb_slot;
    assign cur_slot  = {wc_reg[WB-1:0], hc_reg[HB-1:0]};
    assign prev_slot = {WB'(wc_reg - WC'(1)), p_reg[HB-1:0]};
    assign tb_slot   = {WB'(tw_reg - WC'(1)), th_reg};

    // multiplier operand select
    always_comb
    begin
        mul_a = em_reg;
        mul_b = tag_ok ? init_rd_reg : '0;
        mul_tiny = 1'b1;
        case (state_reg)
            S_PM1:
            begin
                mul_a = prev_sc_reg[p_reg[HB-1:0]];
                mul_b = (32'(tag_rd_reg) < 32'(NUM_TAGS) && tag_ok) ? trans_rd_reg : '0;
                mul_tiny = 1'b0;
            end
            S_PM2:
            begin
                mul_a = mul_q;
                mul_b = em_reg;
            end
            default:
            begin
            end
        endcase
    end

    // table writes and reads
    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == OP_LOAD_TRANS && src_ok_c && tag_ok_c)
            trans_mem[{source_tag[TB-1:0], cand_tag[TB-1:0]}] <= score_value;
        if (in_fire && opcode == OP_LOAD_INIT && tag_ok_c)
            init_mem[cand_tag[TB-1:0]] <= score_value;
        if (state_reg == S_FW0)
            init_rd_reg <= init_mem[tag_reg[TB-1:0]];
        if (state_reg == S_PRD)
            tag_rd_reg <= tag_mem[prev_slot];
        if (state_reg == S_PFW)
            trans_rd_reg <= trans_mem[{tag_rd_reg[TB-1:0], tag_reg[TB-1:0]}];
        if (state_reg == S_TRD)
        begin
            tag_rd_reg <= tag_mem[tb_slot];
            bp_rd_reg  <= bp_mem[tb_slot];
        end
        if (state_reg == S_FIN && wc_reg < WC'(MAX_WORDS) && hc_reg < HC'(MAX_HYPS))
        begin
            tag_mem[cur_slot] <= tag_reg;
            bp_mem[cur_slot]  <= bestp_reg;
        end
    end

    logic tb_go;
    assign tb_go = out_valid && out_ready;
    logic accept_hyp;
    assign accept_hyp = (wc_reg < WC'(MAX_WORDS)) && (hc_reg < HC'(MAX_HYPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wc_reg <= '0; hc_reg <= '0; phc_reg <= '0; ovf_reg <= 1'b0;
            out_valid <= 1'b0;
            p_reg <= '0; have_reg <= 1'b0; k_reg <= '0; tw_reg <= '0; th_reg <= '0;
            tag_reg <= '0; em_reg <= '0; wend_reg <= 1'b0; send_reg <= 1'b0;
            best_reg <= '0; bestp_reg <= '0;
            word_index <= '0; chosen_tag <= '0; overflow_flag <= 1'b0; last_out <= 1'b0;
            for (int i = 0; i < MAX_HYPS; i++)
            begin
                prev_sc_reg[i] <= '0;
                cur_sc_reg[i]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_fire && opcode == OP_HYP)
                    begin
                        tag_reg <= cand_tag; em_reg <= score_value;
                        wend_reg <= word_end; send_reg <= segment_end;
                        p_reg <= '0; have_reg <= 1'b0;
                        best_reg <= '0; bestp_reg <= '0;
                        if (!accept_hyp)
                        begin
                            ovf_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        else if (wc_reg == '0)
                            state_reg <= S_FW0;
                        else
                            state_reg <= S_PRD;
                    end
                S_FW0: state_reg <= S_FW1;
                S_FW1: state_reg <= S_PM3;
                S_PRD:
                    if (p_reg >= phc_reg)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_PFW;
                S_PFW: state_reg <= S_PM1;
                S_PM1: state_reg <= S_PM2;
                S_PM2: state_reg <= (wc_reg == '0) ? S_FIN : S_PCMP;
                S_PM3:
                begin
                    best_reg <= mul_q;
                    state_reg <= S_FIN;
                end
                S_PCMP:
                begin
                    if (!have_reg || mul_q > best_reg)
                    begin
                        best_reg <= mul_q;
                        bestp_reg <= p_reg[HB-1:0];
                        have_reg <= 1'b1;
                    end
                    p_reg <= p_reg + HC'(1);
                    state_reg <= S_PRD;
                end
                S_FIN:
                begin
                    logic [HC-1:0] hc_new;
                    hc_new = hc_reg;
                    if (accept_hyp)
                    begin
                        cur_sc_reg[hc_reg[HB-1:0]] <= best_reg;
                        hc_new = hc_reg + HC'(1);
                    end
                    if (wend_reg || send_reg)
                    begin
                        if (wc_reg < WC'(MAX_WORDS) && hc_new != '0)
                        begin
                            for (int i = 0; i < MAX_HYPS; i++)
                                prev_sc_reg[i] <= (accept_hyp && i == int'(hc_reg))
                                                  ? best_reg : cur_sc_reg[i];
                            phc_reg <= hc_new;
                            wc_reg <= wc_reg + WC'(1);
                        end
                        hc_reg <= '0;
                    end
                    else
                        hc_reg <= hc_new;
                    state_reg <= send_reg ? S_TB0 : S_IDLE;
                end
                S_TB0:
                begin
                    k_reg <= '0; th_reg <= '0;
                    tw_reg <= wc_reg;
                    if (wc_reg == '0 || phc_reg == '0)
                        state_reg <= S_TOUT;
                    else
                        state_reg <= S_TBS;
                end
                S_TBS:
                    if (k_reg >= phc_reg)
                        state_reg <= S_TRD;
                    else
                    begin
                        if (k_reg == '0 || prev_sc_reg[k_reg[HB-1:0]] > best_reg)
                        begin
                            best_reg <= prev_sc_reg[k_reg[HB-1:0]];
                            th_reg <= k_reg[HB-1:0];
                        end
                        k_reg <= k_reg + HC'(1);
                    end
                S_TRD:
                begin
                    // wait for the previous transfer before emitting or finishing
                    if (!out_valid)
                        state_reg <= S_TOUT;
                end
                S_TOUT:
                begin
                    if (tw_reg == '0)
                    begin
                        wc_reg <= '0; hc_reg <= '0; phc_reg <= '0; ovf_reg <= 1'b0;
                        for (int i = 0; i < MAX_HYPS; i++)
                        begin
                            prev_sc_reg[i] <= '0;
                            cur_sc_reg[i]  <= '0;
                        end
                        if (!out_valid)
                            state_reg <= S_IDLE;
                    end
                    else if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        word_index <= WIDX_W'(tw_reg - WC'(1));
                        chosen_tag <= tag_rd_reg;
                        overflow_flag <= ovf_reg;
                        last_out <= (tw_reg == WC'(1));
                        th_reg <= bp_rd_reg;
                        tw_reg <= tw_reg - WC'(1);
                        state_reg <= S_TRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (tb_go)
                out_valid <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_only_tb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (state_reg == S_TRD)) else $error("result outside traceback");
    a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= HC'(MAX_HYPS)) else $error("hyp count past bound");
    a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= WC'(MAX_WORDS)) else $error("word count past bound");
`endif
endmodule
`default_nettype wire

>>> test/viterbi_tag_decoder_core_test.sv
// Self-checking testbench for the Viterbi tag decoder core.
`timescale 1ns / 100ps
`default_nettype none
module viterbi_tag_decoder_core_test;
    import vtd_pkg::*;

    localparam int NTAGS   = NUM_TAGS_DEF;
    localparam int NHYPS   = MAX_HYPS_DEF;
    localparam int NWORDS  = MAX_WORDS_DEF;
    localparam int TINY    = TINY_LSB_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TAG_W-1:0]   cand;
        logic [TAG_W-1:0]   src;
        logic [SCORE_W-1:0] val;
        logic               wend;
        logic               send;
    } tag_item_t;

    typedef struct packed {
        logic [WIDX_W-1:0] widx;
        logic [TAG_W-1:0]  tag;
        logic              ovf;
        logic              last;
    } tag_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [OP_W-1:0] opcode = '0;
    logic [TAG_W-1:0] cand_tag = '0;
    logic [TAG_W-1:0] source_tag = '0;
    logic [SCORE_W-1:0] score_value = '0;
    logic word_end = 1'b0;
    logic segment_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [WIDX_W-1:0] word_index;
    logic [TAG_W-1:0] chosen_tag;
    logic overflow_flag;
    logic last_out;

    viterbi_tag_decoder_core dut (.*);

    always #5 clk = ~clk;

    tag_item_t   pending_items[$];
    tag_result_t expected_tags[$];
    bit calm = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int segments_sent = 0;
    int stall_cycles = 0;

    // predictor state
    logic [SCORE_W-1:0] trans_tab [NTAGS*NTAGS];
    logic [SCORE_W-1:0] init_tab [NTAGS];
    logic [SCORE_W-1:0] prev_sc [NHYPS];
    logic [SCORE_W-1:0] cur_sc [NHYPS];
    logic [TAG_W-1:0]   tag_mem [NWORDS*NHYPS];
    logic [3:0]         bp_mem [NWORDS*NHYPS];
    int  n_words, n_hyps, n_prev_hyps;
    bit  seg_ovf;

    // tags used by hypotheses: every bit of the tag toggles within this set
    logic [TAG_W-1:0] live_tags [8] = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32};

    function automatic logic [SCORE_W-1:0] frac_mul(logic [SCORE_W-1:0] a,
                                                    logic [SCORE_W-1:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:32];
    endfunction

    function automatic logic [SCORE_W-1:0] plus_tiny(logic [SCORE_W-1:0] x);
        logic [32:0] s;
        s = 33'(x) + 33'(TINY);
        return s[32] ? '1 : s[31:0];
    endfunction

    task automatic clear_segment();
        n_words = 0;
        n_hyps = 0;
        n_prev_hyps = 0;
        seg_ovf = 1'b0;
        for (int i = 0; i < NHYPS; i++)
        begin
            prev_sc[i] = '0;
            cur_sc[i] = '0;
        end
    endtask

    task automatic predict_tags(tag_item_t it);
        int slot, h, base;
        logic [SCORE_W-1:0] best, s;
        tag_result_t r;
        case (it.op)
            OP_LOAD_TRANS: trans_tab[it.src*NTAGS + it.cand] = it.val;
            OP_LOAD_INIT:  init_tab[it.cand] = it.val;
            OP_HYP:
            begin
                if (n_words >= NWORDS || n_hyps >= NHYPS)
                    seg_ovf = 1'b1;
                else
                begin
                    slot = n_words*NHYPS + n_hyps;
                    tag_mem[slot] = it.cand;
                    best = '0;
                    h = 0;
                    if (n_words == 0)
                        best = plus_tiny(frac_mul(init_tab[it.cand], it.val));
                    else
                    begin
                        base = (n_words - 1)*NHYPS;
                        for (int p = 0; p < n_prev_hyps; p++)
                        begin
                            s = frac_mul(prev_sc[p], trans_tab[tag_mem[base+p]*NTAGS + it.cand]);
                            s = plus_tiny(frac_mul(s, it.val));
                            if (p == 0 || s > best)
                            begin
                                best = s;
                                h = p;
                            end
                        end
                    end
                    cur_sc[n_hyps] = best;
                    bp_mem[slot] = 4'(h);
                    n_hyps++;
                end
                if (it.wend || it.send)
                begin
                    if (n_words < NWORDS && n_hyps > 0)
                    begin
                        prev_sc = cur_sc;
                        n_prev_hyps = n_hyps;
                        n_words++;
                    end
                    n_hyps = 0;
                end
                if (it.send)
                begin
                    if (n_words > 0 && n_prev_hyps > 0)
                    begin
                        h = 0;
                        for (int k = 0; k < n_prev_hyps; k++)
                            if (k == 0 || prev_sc[k] > prev_sc[h])
                                h = k;
                        for (int w = n_words; w > 0; w--)
                        begin
                            slot = (w - 1)*NHYPS + h;
                            r.widx = WIDX_W'(w - 1);
                            r.tag = tag_mem[slot];
                            r.ovf = seg_ovf;
                            r.last = (w == 1);
                            expected_tags.push_back(r);
                            h = bp_mem[slot];
                        end
                    end
                    clear_segment();
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 31);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_tags({opcode, cand_tag, source_tag, score_value, word_end,
                              segment_end});
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && !idle_now())
                begin
                    tag_item_t it;
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    opcode <= it.op;
                    cand_tag <= it.cand;
                    source_tag <= it.src;
                    score_value <= it.val;
                    word_end <= it.wend;
                    segment_end <= it.send;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !idle_now();
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_tags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: idx %0d tag %0d ovf %0b last %0b",
                                 word_index, chosen_tag, overflow_flag, last_out);
                end
                else
                begin
                    tag_result_t e;
                    e = expected_tags.pop_front();
                    if (e.widx !== word_index || e.tag !== chosen_tag ||
                        e.ovf !== overflow_flag || e.last !== last_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp idx %0d tag %0d ovf %0b last %0b,",
                                      " got idx %0d tag %0d ovf %0b last %0b"},
                                     e.widx, e.tag, e.ovf, e.last,
                                     word_index, chosen_tag, overflow_flag, last_out);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_item(logic [OP_W-1:0] op, int c, int s, logic [31:0] v,
                            bit we, bit se);
        tag_item_t it;
        it.op = op;
        it.cand = TAG_W'(c);
        it.src = TAG_W'(s);
        it.val = v;
        it.wend = we;
        it.send = se;
        pending_items.push_back(it);
        if (op == OP_HYP && se)
            segments_sent++;
    endtask

    function automatic logic [31:0] rand_score();
        case ($urandom_range(7))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_tag();
        return live_tags[$urandom_range(7)];
    endfunction

    task automatic add_segment(int words, int max_hyps, bit drop_wend);
        int nh;
        for (int w = 0; w < words; w++)
        begin
            nh = $urandom_range(max_hyps, 1);
            for (int h = 0; h < nh; h++)
                add_item(OP_HYP, rand_tag(), $urandom_range(63), rand_score(),
                         (h == nh - 1) && !(drop_wend && w == words - 1),
                         (h == nh - 1) && (w == words - 1));
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_tags.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_segment();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // fill tables for every tag a hypothesis may use
        for (int a = 0; a < 8; a++)
            add_item(OP_LOAD_INIT, live_tags[a], $urandom_range(63),
                     (live_tags[a] == 6'd63) ? 32'hFFFF_FFFF : rand_score(), 0, 0);
        for (int a = 0; a < 8; a++)
            for (int b = 0; b < 8; b++)
                add_item(OP_LOAD_TRANS, live_tags[b], live_tags[a],
                         (a == 1 && b == 1) ? 32'hFFFF_FFFF : $urandom, 0, 0);

        // directed cases
        add_item(OP_HYP, 63, 0, 32'hFFFF_FFFF, 1, 1);       // max scores, one word
        add_item(OP_HYP, 0, 0, 32'h0, 0, 0);                // tie on first word
        add_item(OP_HYP, 0, 0, 32'h0, 1, 0);
        add_item(OP_HYP, 1, 0, 32'h0, 0, 0);                // tie among predecessors
        add_item(OP_HYP, 2, 0, 32'h0, 0, 1);                // segment end without word end
        add_item(OP_NONE, 5, 9, 32'hDEAD_BEEF, 1, 1);       // ignored opcode
        add_item(OP_LOAD_TRANS, 1, 63, 32'h8000_0000, 0, 0);
        add_item(OP_HYP, 63, 0, 32'h8000_0000, 1, 0);
        add_item(OP_HYP, 1, 0, 32'hFFFF_FFFF, 1, 1);
        drain();

        // too many hypotheses in one word
        for (int h = 0; h <= NHYPS; h++)
            add_item(OP_HYP, rand_tag(), 0, rand_score(), h == NHYPS, 0);
        add_item(OP_HYP, rand_tag(), 0, rand_score(), 1, 1);
        // too many words
        add_segment(NWORDS + 1, 1, 0);
        drain();

        // random part, first stretch without idling
        calm = 1'b1;
        repeat (4) add_segment($urandom_range(4, 1), 3, 0);
        drain();
        calm = 1'b0;
        while (items_sent < 180)
        begin
            case ($urandom_range(9))
                0: add_item(OP_LOAD_TRANS, rand_tag(), rand_tag(), $urandom, 0, 0);
                1: add_item(OP_LOAD_INIT, rand_tag(), $urandom_range(63), $urandom, 0, 0);
                2: add_item(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom,
                            $urandom_range(1), $urandom_range(1));
                3: add_segment($urandom_range(6, 1), 5, 1);
                4: add_segment($urandom_range(2, 1), 18, 0);
                default: add_segment($urandom_range(6, 1), 4, 0);
            endcase
            drain();
        end

        repeat (200) @(posedge clk);
        $display("%0d items sent in %0d segments, %0d tags traced back, including overflow cases",
                 items_sent, segments_sent, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/vtd_pkg.sv
hw/rtl/vtd_mul.sv
hw/rtl/viterbi_tag_decoder_core.sv
test/viterbi_tag_decoder_core_test.sv
